### rtl/sbcs_pkg.sv
// Package for the swept box contact side block: widths, side codes and the
// request and stage payload types shared by every module of the pipeline.
// Depends on nothing.
`default_nettype none

package sbcs_pkg;

    // Field widths of the request and response
    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = 12;
    localparam int STEP_BITS  = 11;
    localparam int SIDE_BITS  = 3;

    // Extended coordinate: holds coord + size and a tracking point minus a step
    localparam int EXT_BITS   = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS + 1) + 2;
    // Difference of two extended coordinates
    localparam int DIFF_BITS  = EXT_BITS + 1;
    // Difference times a step component
    localparam int PROD_BITS  = DIFF_BITS + STEP_BITS;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [SIZE_BITS-1:0]  t_size;
    typedef logic signed [STEP_BITS-1:0]  t_step;
    typedef logic signed [EXT_BITS-1:0]   t_ext;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;

    // Side of the fixed box that was touched
    typedef enum logic [SIDE_BITS-1:0] {
        SIDE_NONE   = 3'd0,
        SIDE_LEFT   = 3'd1,
        SIDE_TOP    = 3'd2,
        SIDE_RIGHT  = 3'd3,
        SIDE_BOTTOM = 3'd4
    } t_side;

    // One request as taken from the input channel
    typedef struct packed {
        t_coord mover_x;
        t_coord mover_y;
        t_size  mover_w;
        t_size  mover_h;
        t_step  step_x;
        t_step  step_y;
        t_coord solid_x;
        t_coord solid_y;
        t_size  solid_w;
        t_size  solid_h;
    } t_req;

    // After overlap and adjacency
    typedef struct packed {
        logic  go;
        t_side adj;
        t_step vx;
        t_step vy;
        t_ext  ox;
        t_ext  oy;
        t_ext  rx;
        t_ext  by;
        t_ext  el;
        t_ext  et;
        t_ext  er;
        t_ext  eb;
    } t_s1;

    // After tracking point selection
    typedef struct packed {
        logic  go;
        t_side adj;
        t_step vx;
        t_step vy;
        t_ext  px;
        t_ext  py;
        t_ext  el;
        t_ext  et;
        t_ext  er;
        t_ext  eb;
    } t_s2;

    // Range flags of the swept segment against the edge lines
    typedef struct packed {
        logic in_l;
        logic in_r;
        logic in_t;
        logic in_b;
        logic ov_x;
        logic ov_y;
    } t_span;

    // After segment start and edge differences
    typedef struct packed {
        logic  go;
        t_side adj;
        t_step vx;
        t_step vy;
        t_diff dl;
        t_diff dr;
        t_diff dt;
        t_diff db;
        t_span span;
    } t_s3;

    // After cross products
    typedef struct packed {
        logic  go;
        t_side adj;
        logic  vx_nz;
        logic  vy_nz;
        t_prod pl;
        t_prod pr;
        t_prod pt;
        t_prod pb;
        t_span span;
    } t_s4;

endpackage

`default_nettype wire

### rtl/sbcs_if.sv
// Request and response channel interfaces of the swept box contact side block.
// Depends on sbcs_pkg for field widths.
`default_nettype none

interface sbcs_req_if;
    logic                   valid;
    logic                   ready;
    sbcs_pkg::t_coord       mover_x;
    sbcs_pkg::t_coord       mover_y;
    sbcs_pkg::t_size        mover_w;
    sbcs_pkg::t_size        mover_h;
    sbcs_pkg::t_step        step_x;
    sbcs_pkg::t_step        step_y;
    sbcs_pkg::t_coord       solid_x;
    sbcs_pkg::t_coord       solid_y;
    sbcs_pkg::t_size        solid_w;
    sbcs_pkg::t_size        solid_h;

    modport source (
        output valid, mover_x, mover_y, mover_w, mover_h, step_x, step_y,
               solid_x, solid_y, solid_w, solid_h,
        input  ready
    );
    modport sink (
        input  valid, mover_x, mover_y, mover_w, mover_h, step_x, step_y,
               solid_x, solid_y, solid_w, solid_h,
        output ready
    );
endinterface

interface sbcs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [sbcs_pkg::SIDE_BITS-1:0]  side;

    modport source (output valid, side, input ready);
    modport sink   (input valid, side, output ready);
endinterface

`default_nettype wire

### rtl/sbcs_front.sv
// First pipeline stage: overlap rectangle, motion check and edge adjacency.
// Depends on sbcs_pkg.
`default_nettype none

module sbcs_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire sbcs_pkg::t_req i_req,
    output logic                o_valid,
    output sbcs_pkg::t_s1       o_s1
);

    function automatic sbcs_pkg::t_ext ext_coord(input sbcs_pkg::t_coord v);
        return {{(sbcs_pkg::EXT_BITS-sbcs_pkg::COORD_BITS){v[sbcs_pkg::COORD_BITS-1]}}, v};
    endfunction

    function automatic sbcs_pkg::t_ext ext_size(input sbcs_pkg::t_size v);
        return {{(sbcs_pkg::EXT_BITS-sbcs_pkg::SIZE_BITS){1'b0}}, v};
    endfunction

    sbcs_pkg::t_ext mx, my, mw, mh, sx, sy, sw, sh;
    sbcs_pkg::t_ext mr, mb, sr, sb, ml;
    logic           sizes_ok, moving, xspan, yspan;
    sbcs_pkg::t_s1  n_s1;
    sbcs_pkg::t_s1  r_s1;
    logic           r_vld;

    // Widen the fields and form the box ends
    always_comb begin
        mx = ext_coord(i_req.mover_x);
        my = ext_coord(i_req.mover_y);
        mw = ext_size(i_req.mover_w);
        mh = ext_size(i_req.mover_h);
        sx = ext_coord(i_req.solid_x);
        sy = ext_coord(i_req.solid_y);
        sw = ext_size(i_req.solid_w);
        sh = ext_size(i_req.solid_h);
        mr = mx + mw;
        mb = my + mh;
        sr = sx + sw;
        sb = sy + sh;
        ml = mx - sw;
    end

    // Overlap rectangle, swept-test enable and adjacency side
    always_comb begin
        sizes_ok = (i_req.mover_w != '0) && (i_req.mover_h != '0) &&
                   (i_req.solid_w != '0) && (i_req.solid_h != '0);
        moving   = (i_req.step_x != '0) || (i_req.step_y != '0);

        n_s1.vx = i_req.step_x;
        n_s1.vy = i_req.step_y;
        n_s1.ox = (mx > sx) ? mx : sx;
        n_s1.oy = (my > sy) ? my : sy;
        n_s1.rx = (mr < sr) ? mr : sr;
        n_s1.by = (mb < sb) ? mb : sb;
        n_s1.el = sx;
        n_s1.et = sy;
        n_s1.er = sr;
        n_s1.eb = sb;
        n_s1.go = sizes_ok && moving && (n_s1.rx > n_s1.ox) && (n_s1.by > n_s1.oy);

        xspan = (sx > ml) && (sx < mr);
        yspan = (sb > my) && (sy < mb);
        if ((sy == mb) && xspan) begin
            n_s1.adj = sbcs_pkg::SIDE_TOP;
        end else if ((sx == ml) && yspan) begin
            n_s1.adj = sbcs_pkg::SIDE_RIGHT;
        end else if ((sx == mr) && yspan) begin
            n_s1.adj = sbcs_pkg::SIDE_LEFT;
        end else if ((sb == my) && xspan) begin
            n_s1.adj = sbcs_pkg::SIDE_BOTTOM;
        end else begin
            n_s1.adj = sbcs_pkg::SIDE_NONE;
        end
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    // Hold the stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_vld;
    assign o_s1    = r_s1;

endmodule

`default_nettype wire

### rtl/sbcs_track.sv
// Second and third pipeline stages: tracking point on the overlap border,
// swept segment start, edge differences and range flags. Depends on sbcs_pkg.
`default_nettype none

module sbcs_track (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_en,
    input  wire logic          i_valid,
    input  wire sbcs_pkg::t_s1 i_s1,
    output logic [1:0]         o_vld,
    output sbcs_pkg::t_s3      o_s3
);

    function automatic sbcs_pkg::t_ext ext_step(input sbcs_pkg::t_step v);
        return {{(sbcs_pkg::EXT_BITS-sbcs_pkg::STEP_BITS){v[sbcs_pkg::STEP_BITS-1]}}, v};
    endfunction

    function automatic sbcs_pkg::t_diff ext_diff(input sbcs_pkg::t_ext v);
        return {v[sbcs_pkg::EXT_BITS-1], v};
    endfunction

    sbcs_pkg::t_ext ow, oh;
    logic           vx_neg, vy_neg, vx_pos, vy_pos;
    sbcs_pkg::t_s2  n_s2, r_s2;
    sbcs_pkg::t_ext ax, ay, lox, hix, loy, hiy;
    sbcs_pkg::t_s3  n_s3, r_s3;
    logic [1:0]     r_vld;

    // Pick the tracking point by the direction of the step
    always_comb begin
        vx_neg = i_s1.vx[sbcs_pkg::STEP_BITS-1];
        vy_neg = i_s1.vy[sbcs_pkg::STEP_BITS-1];
        vx_pos = !vx_neg && (i_s1.vx != '0);
        vy_pos = !vy_neg && (i_s1.vy != '0);
        ow     = i_s1.rx - i_s1.ox;
        oh     = i_s1.by - i_s1.oy;

        n_s2.go  = i_s1.go;
        n_s2.adj = i_s1.adj;
        n_s2.vx  = i_s1.vx;
        n_s2.vy  = i_s1.vy;
        n_s2.el  = i_s1.el;
        n_s2.et  = i_s1.et;
        n_s2.er  = i_s1.er;
        n_s2.eb  = i_s1.eb;
        if (vx_pos) begin
            n_s2.px = i_s1.rx;
        end else if (vx_neg) begin
            n_s2.px = i_s1.ox;
        end else begin
            n_s2.px = i_s1.ox + (ow >>> 1);
        end
        if (vy_pos) begin
            n_s2.py = i_s1.by;
        end else if (vy_neg) begin
            n_s2.py = i_s1.oy;
        end else begin
            n_s2.py = i_s1.oy + (oh >>> 1);
        end
    end

    // Segment start, bounding box of the segment and edge differences
    always_comb begin
        ax  = r_s2.px - ext_step(r_s2.vx);
        ay  = r_s2.py - ext_step(r_s2.vy);
        lox = r_s2.vx[sbcs_pkg::STEP_BITS-1] ? r_s2.px : ax;
        hix = r_s2.vx[sbcs_pkg::STEP_BITS-1] ? ax : r_s2.px;
        loy = r_s2.vy[sbcs_pkg::STEP_BITS-1] ? r_s2.py : ay;
        hiy = r_s2.vy[sbcs_pkg::STEP_BITS-1] ? ay : r_s2.py;

        n_s3.go  = r_s2.go;
        n_s3.adj = r_s2.adj;
        n_s3.vx  = r_s2.vx;
        n_s3.vy  = r_s2.vy;
        n_s3.dl  = ext_diff(r_s2.el) - ext_diff(ax);
        n_s3.dr  = ext_diff(r_s2.er) - ext_diff(ax);
        n_s3.dt  = ext_diff(r_s2.et) - ext_diff(ay);
        n_s3.db  = ext_diff(r_s2.eb) - ext_diff(ay);

        n_s3.span.in_l = (r_s2.el >= lox) && (r_s2.el <= hix);
        n_s3.span.in_r = (r_s2.er >= lox) && (r_s2.er <= hix);
        n_s3.span.in_t = (r_s2.et >= loy) && (r_s2.et <= hiy);
        n_s3.span.in_b = (r_s2.eb >= loy) && (r_s2.eb <= hiy);
        n_s3.span.ov_x = (hix >= r_s2.el) && (lox <= r_s2.er);
        n_s3.span.ov_y = (hiy >= r_s2.et) && (loy <= r_s2.eb);
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (i_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    // Hold the stage payloads
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s2 <= n_s2;
        end
        if (i_en[1]) begin
            r_s3 <= n_s3;
        end
    end

    assign o_vld = r_vld;
    assign o_s3  = r_s3;

endmodule

`default_nettype wire

### rtl/sbcs_edge.sv
// Fourth and fifth pipeline stages: cross products of the edge differences
// with the step, edge hit tests and the registered side. Depends on sbcs_pkg.
`default_nettype none

module sbcs_edge (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [1:0]    i_en,
    input  wire logic          i_valid,
    input  wire sbcs_pkg::t_s3 i_s3,
    output logic [1:0]         o_vld,
    output sbcs_pkg::t_side    o_side
);

    // True when a lies between e0 and e1, either way round, ends included
    function automatic logic between(input sbcs_pkg::t_prod a,
                                     input sbcs_pkg::t_prod e0,
                                     input sbcs_pkg::t_prod e1);
        return ((a >= e0) && (a <= e1)) || ((a <= e0) && (a >= e1));
    endfunction

    sbcs_pkg::t_s4   n_s4, r_s4;
    logic            hit_l, hit_r, hit_t, hit_b;
    sbcs_pkg::t_side n_side, r_side;
    logic [1:0]      r_vld;

    // Form the four cross products
    always_comb begin
        n_s4.go    = i_s3.go;
        n_s4.adj   = i_s3.adj;
        n_s4.vx_nz = (i_s3.vx != '0);
        n_s4.vy_nz = (i_s3.vy != '0);
        n_s4.pl    = i_s3.dl * i_s3.vy;
        n_s4.pr    = i_s3.dr * i_s3.vy;
        n_s4.pt    = i_s3.dt * i_s3.vx;
        n_s4.pb    = i_s3.db * i_s3.vx;
        n_s4.span  = i_s3.span;
    end

    // Test each edge; a parallel step falls back to the collinear overlap
    always_comb begin
        hit_l = r_s4.span.in_l &&
                (r_s4.vx_nz ? between(r_s4.pl, r_s4.pt, r_s4.pb) : r_s4.span.ov_y);
        hit_r = r_s4.span.in_r &&
                (r_s4.vx_nz ? between(r_s4.pr, r_s4.pt, r_s4.pb) : r_s4.span.ov_y);
        hit_t = r_s4.span.in_t &&
                (r_s4.vy_nz ? between(r_s4.pt, r_s4.pl, r_s4.pr) : r_s4.span.ov_x);
        hit_b = r_s4.span.in_b &&
                (r_s4.vy_nz ? between(r_s4.pb, r_s4.pl, r_s4.pr) : r_s4.span.ov_x);

        // Later edges in left, top, right, bottom order win
        n_side = sbcs_pkg::SIDE_NONE;
        if (r_s4.go) begin
            if (hit_b) begin
                n_side = sbcs_pkg::SIDE_BOTTOM;
            end else if (hit_r) begin
                n_side = sbcs_pkg::SIDE_RIGHT;
            end else if (hit_t) begin
                n_side = sbcs_pkg::SIDE_TOP;
            end else if (hit_l) begin
                n_side = sbcs_pkg::SIDE_LEFT;
            end
        end
        // Adjacency overrides the swept answer
        if (r_s4.adj != sbcs_pkg::SIDE_NONE) begin
            n_side = r_s4.adj;
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (i_en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (i_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    // Hold the stage payloads
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s4 <= n_s4;
        end
        if (i_en[1]) begin
            r_side <= n_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_side = r_side;

endmodule

`default_nettype wire

### rtl/swept_box_contact_side.sv
// Swept box contact side: five stages, one pair per cycle unless stalled.
// Depends on sbcs_pkg, sbcs_if, sbcs_front, sbcs_track and sbcs_edge.
`default_nettype none

// The block takes one request per clock unless a stalled response backs up
// to the first stage, and returns one side code per request, in order. The
// five register stages are the overlap and adjacency
// stage, the tracking point stage, the segment difference stage, the
// multiplier stage and the hit test stage, whose register drives the
// response channel. Each stage advances when it is empty or the stage after
// it advances, so bubbles close up and a stalled response holds only as much
// of the pipeline as is full. There is no stored state beyond the pipeline
// and no start-up delay after reset.
module swept_box_contact_side (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sbcs_req_if.sink   i_req,
    sbcs_rsp_if.source o_rsp
);

    sbcs_pkg::t_req  req;
    sbcs_pkg::t_s1   s1;
    sbcs_pkg::t_s3   s3;
    sbcs_pkg::t_side side;
    logic [4:0]      stage_vld;
    logic [4:0]      stage_en;

    // Gather the request fields
    always_comb begin
        req.mover_x = i_req.mover_x;
        req.mover_y = i_req.mover_y;
        req.mover_w = i_req.mover_w;
        req.mover_h = i_req.mover_h;
        req.step_x  = i_req.step_x;
        req.step_y  = i_req.step_y;
        req.solid_x = i_req.solid_x;
        req.solid_y = i_req.solid_y;
        req.solid_w = i_req.solid_w;
        req.solid_h = i_req.solid_h;
    end

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        stage_en[4] = !stage_vld[4] || o_rsp.ready;
        stage_en[3] = !stage_vld[3] || stage_en[4];
        stage_en[2] = !stage_vld[2] || stage_en[3];
        stage_en[1] = !stage_vld[1] || stage_en[2];
        stage_en[0] = !stage_vld[0] || stage_en[1];
    end

    assign i_req.ready = stage_en[0];

    sbcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (stage_en[0]),
        .i_valid (i_req.valid),
        .i_req   (req),
        .o_valid (stage_vld[0]),
        .o_s1    (s1)
    );

    sbcs_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (stage_en[2:1]),
        .i_valid (stage_vld[0]),
        .i_s1    (s1),
        .o_vld   (stage_vld[2:1]),
        .o_s3    (s3)
    );

    sbcs_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (stage_en[4:3]),
        .i_valid (stage_vld[2]),
        .i_s3    (s3),
        .o_vld   (stage_vld[4:3]),
        .o_side  (side)
    );

    assign o_rsp.valid = stage_vld[4];
    assign o_rsp.side  = side;

endmodule

`default_nettype wire

### rtl/sbcs_checker.sv
// Port checker for swept_box_contact_side and the bind that attaches it.
// Depends on sbcs_pkg for the side codes.
`default_nettype none

module sbcs_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_req_valid,
    input wire logic                           i_req_ready,
    input wire logic                           i_rsp_valid,
    input wire logic                           i_rsp_ready,
    input wire logic [sbcs_pkg::SIDE_BITS-1:0] i_side
);

    // Response registers come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("response valid right after reset");

    // Only defined side codes leave the block
    a_side_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_side <= sbcs_pkg::SIDE_BOTTOM))
        else $error("undefined side code");

    // An empty output stage never blocks requests
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rsp_valid |-> i_req_ready)
        else $error("request stalled with empty output stage");

    // A stalled response holds its side
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_side)))
        else $error("stalled response changed");

    // With the sink always ready, an accepted request reaches the response channel
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) ##1 i_rsp_ready ##1 i_rsp_ready
            ##1 i_rsp_ready ##1 i_rsp_ready |=> i_rsp_valid)
        else $error("response missing after pipeline latency");

endmodule

bind swept_box_contact_side sbcs_checker u_sbcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_side      (o_rsp.side)
);

`default_nettype wire
